// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions with a reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed in the same cycle");

// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed in the next cycle");

`endif

// File: rtl/core/mrma_pkg.sv
// ----------------------------------------------------------------------------
// mrma_pkg
// Shared widths, codes and control structs of the row multiply-accumulate.
// ----------------------------------------------------------------------------
`default_nettype none

package mrma_pkg;

  localparam int DATA_W = 16;
  localparam int PROD_W = 32;
  localparam int ACC_W  = 48;
  localparam int IDX_W  = 6;
  localparam int CFG_W  = 7;
  localparam int KEXT_W = 11;

  localparam int INNER_DIM_DEF = 64;
  localparam int MAX_COLS_DEF  = 64;

  localparam logic [CFG_W-1:0] COLS_RESET = 7'd64;

  // Item command codes.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_ROW  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;       // capture the accepted item (and write B on a load)
    logic issue;      // start one column of the multiply-accumulate
    logic col_clear;  // reset the column counter
    logic col_inc;    // advance the column counter
    logic emit_read;  // read the accumulator at the column counter
    logic emit_load;  // load the result register
    logic clear_acc;  // mark every accumulator as zero
  } mrma_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic row_item;   // input item is an A row element
    logic item_last;  // input item carries the last flag
    logic row_ok;     // input inner index lies inside the B store
    logic col_last;   // column counter is at the last active column
    logic pipe_busy;  // multiply-accumulate pipeline holds work
    logic out_taken;  // result register transfers this cycle
  } mrma_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/mrma_ctrl.sv
// ----------------------------------------------------------------------------
// mrma_ctrl
// Sequencer: accepts items, steps the column sweep, drains, and emits a row after the last element.
// ----------------------------------------------------------------------------
`default_nettype none

module mrma_ctrl
  import mrma_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      item_valid,
  output logic           item_stall,
  input  wire mrma_sts_t sts,
  output mrma_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_MAC      = 3'd1;
  localparam logic [2:0] S_DRAIN    = 3'd2;
  localparam logic [2:0] S_EMIT_RD  = 3'd3;
  localparam logic [2:0] S_EMIT_LD  = 3'd4;
  localparam logic [2:0] S_EMIT_OUT = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       last_q;
  logic       last_q_next;
  logic       accept;

  // Items are taken only between operations.
  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;

  // Next state and command decode.
  always_comb begin
    state_next  = state;
    last_q_next = last_q;
    cmd         = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.take      = 1'b1;
          cmd.col_clear = 1'b1;
          last_q_next   = sts.item_last;
          if (sts.row_item) begin
            if (sts.row_ok) begin
              state_next = S_MAC;
            end else if (sts.item_last) begin
              state_next = S_EMIT_RD;
            end
          end
        end
      end
      S_MAC: begin
        cmd.issue = 1'b1;
        if (sts.col_last) begin
          state_next = S_DRAIN;
        end else begin
          cmd.col_inc = 1'b1;
        end
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) begin
          cmd.col_clear = 1'b1;
          state_next    = last_q ? S_EMIT_RD : S_IDLE;
        end
      end
      S_EMIT_RD: begin
        cmd.emit_read = 1'b1;
        state_next    = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        cmd.emit_load = 1'b1;
        state_next    = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        if (sts.out_taken) begin
          if (sts.col_last) begin
            cmd.clear_acc = 1'b1;
            state_next    = S_IDLE;
          end else begin
            cmd.col_inc = 1'b1;
            state_next  = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      last_q <= 1'b0;
    end else begin
      state  <= state_next;
      last_q <= last_q_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/mrma_dp.sv
// ----------------------------------------------------------------------------
// mrma_dp
// Datapath: B store, accumulator memory, shared multiply-accumulate pipeline
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mrma_dp
  import mrma_pkg::*;
#(
  parameter int INNER_DIM = INNER_DIM_DEF,
  parameter int MAX_COLS  = MAX_COLS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_W-1:0]         cfg_wdata,
  input  wire logic                     cmd_bit,
  input  wire logic [IDX_W-1:0]         inner_index,
  input  wire logic [IDX_W-1:0]         col_index,
  input  wire logic signed [DATA_W-1:0] value,
  input  wire logic                     last,
  output logic                          result_valid,
  input  wire logic                     result_stall,
  output logic [IDX_W-1:0]              out_col,
  output logic signed [ACC_W-1:0]       product,
  output logic                          row_done,
  input  wire mrma_cmd_t                cmd,
  output mrma_sts_t                     sts
);

  localparam int KW     = (INNER_DIM > 1) ? $clog2(INNER_DIM) : 1;
  localparam int CW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int BDEPTH = 2 ** (KW + CW);

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Storage.
  logic signed [DATA_W-1:0] bmem   [BDEPTH];
  logic signed [ACC_W-1:0]  accmem [MAX_COLS];
  logic [MAX_COLS-1:0]      acc_valid;

  // Configuration and item registers.
  logic [CFG_W-1:0]         cols_cfg;
  logic [KW-1:0]            row_q;
  logic signed [DATA_W-1:0] value_q;
  logic [CW-1:0]            col_cnt;

  // Pipeline registers.
  logic                     p1_v;
  logic [CW-1:0]            p1_col;
  logic signed [DATA_W-1:0] b_rd;
  logic                     p2_v;
  logic [CW-1:0]            p2_col;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_rd;
  logic                     acc_ok;

  // Combinational helpers.
  logic [KEXT_W-1:0]        k_ext;
  logic [CFG_W-1:0]         col_ext;
  logic                     col_ok;
  logic [CFG_W-1:0]         n_active;
  logic [CFG_W-1:0]         n_last;
  logic [CW-1:0]            acc_addr;
  logic signed [ACC_W-1:0]  acc_cur;
  logic signed [ACC_W:0]    sum;
  logic signed [ACC_W-1:0]  sum_sat;

  // Range checks on the incoming item.
  assign k_ext   = KEXT_W'(inner_index);
  assign col_ext = CFG_W'(col_index);
  assign col_ok  = col_ext < CFG_W'(MAX_COLS);

  // Active column count, clamped to one and to the store width.
  always_comb begin
    if (cols_cfg == '0) begin
      n_active = CFG_W'(1);
    end else if (cols_cfg > CFG_W'(MAX_COLS)) begin
      n_active = CFG_W'(MAX_COLS);
    end else begin
      n_active = cols_cfg;
    end
  end
  assign n_last = n_active - CFG_W'(1);

  // Status toward the controller.
  assign sts.row_item  = (cmd_bit == CMD_ROW);
  assign sts.item_last = last;
  assign sts.row_ok    = k_ext < KEXT_W'(INNER_DIM);
  assign sts.col_last  = (col_cnt == n_last[CW-1:0]);
  assign sts.pipe_busy = p1_v || p2_v;
  assign sts.out_taken = result_valid && !result_stall;

  // Column count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cols_cfg <= COLS_RESET;
    end else if (cfg_we) begin
      cols_cfg <= cfg_wdata;
    end
  end

  // Item capture and the B store write port.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      row_q   <= k_ext[KW-1:0];
      value_q <= value;
      if (cmd_bit == CMD_LOAD && sts.row_ok && col_ok) begin
        bmem[{k_ext[KW-1:0], col_ext[CW-1:0]}] <= value;
      end
    end
  end

  // Column counter shared by the sweep and the emission.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
    end else if (cmd.col_clear) begin
      col_cnt <= '0;
    end else if (cmd.col_inc) begin
      col_cnt <= col_cnt + CW'(1);
    end
  end

  // Stage one: read B at the issued column.
  always_ff @(posedge clk) begin
    b_rd   <= bmem[{row_q, col_cnt}];
    p1_col <= col_cnt;
  end

  // Stage two: multiply and read the accumulator of the same column. During an
  // emission the accumulator is read at the column counter instead.
  assign acc_addr = cmd.emit_read ? col_cnt : p1_col;

  always_ff @(posedge clk) begin
    prod_q <= value_q * b_rd;
    p2_col <= p1_col;
    acc_rd <= accmem[acc_addr];
    acc_ok <= acc_valid[acc_addr];
  end

  // An accumulator not written since the last clear reads as zero.
  assign acc_cur = acc_ok ? acc_rd : '0;

  // Stage three: saturating add and write back.
  assign sum = (ACC_W+1)'(acc_cur) + (ACC_W+1)'(prod_q);

  always_comb begin
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      sum_sat = sum[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sum_sat = sum[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (p2_v) begin
      accmem[p2_col] <= sum_sat;
    end
  end

  // Pipeline valid flags and accumulator valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v      <= 1'b0;
      p2_v      <= 1'b0;
      acc_valid <= '0;
    end else begin
      p1_v <= cmd.issue;
      p2_v <= p1_v;
      if (cmd.clear_acc) begin
        acc_valid <= '0;
      end else if (p2_v) begin
        acc_valid[p2_col] <= 1'b1;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_col  <= IDX_W'(col_cnt);
      product  <= acc_cur;
      row_done <= sts.col_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit_load) begin
      result_valid <= 1'b1;
    end else if (sts.out_taken) begin
      result_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/matrix_row_multiply_accumulate.sv
// A load item is written to the B store as it is accepted; a row element sweeps the n active columns, then drains.
// Throughput: one shared multiply-accumulate unit handles one column per cycle.
// A last element then emits the n results one after another, each held through any output stall.
// Reset (rst, synchronous) sets the column count to 64 and zeroes all accumulators.
// The B store is not cleared and holds unknown data until written.
// ----------------------------------------------------------------------------
// matrix_row_multiply_accumulate
// One row of C = A * B with 16-bit elements and saturating 48-bit sums.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_row_multiply_accumulate
  import mrma_pkg::*;
#(
  parameter int INNER_DIM = INNER_DIM_DEF,
  parameter int MAX_COLS  = MAX_COLS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_W-1:0]         cfg_wdata,
  input  wire logic                     item_valid,
  output logic                          item_stall,
  input  wire logic                     cmd,
  input  wire logic [IDX_W-1:0]         inner_index,
  input  wire logic [IDX_W-1:0]         col_index,
  input  wire logic signed [DATA_W-1:0] value,
  input  wire logic                     last,
  output logic                          result_valid,
  input  wire logic                     result_stall,
  output logic [IDX_W-1:0]              out_col,
  output logic signed [ACC_W-1:0]       product,
  output logic                          row_done
);

  mrma_cmd_t dp_cmd;
  mrma_sts_t dp_sts;

  // Sequencer.
  mrma_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .sts        (dp_sts),
    .cmd        (dp_cmd)
  );

  // Storage and arithmetic.
  mrma_dp #(
    .INNER_DIM (INNER_DIM),
    .MAX_COLS  (MAX_COLS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .cmd_bit      (cmd),
    .inner_index  (inner_index),
    .col_index    (col_index),
    .value        (value),
    .last         (last),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_col      (out_col),
    .product      (product),
    .row_done     (row_done),
    .cmd          (dp_cmd),
    .sts          (dp_sts)
  );

endmodule

`default_nettype wire

// File: rtl/core/mrma_checker.sv
// ----------------------------------------------------------------------------
// mrma_checker
// Port-level checks of the row multiply-accumulate, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mrma_checker
  import mrma_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     item_valid,
  input wire logic                     item_stall,
  input wire logic                     result_valid,
  input wire logic                     result_stall,
  input wire logic [IDX_W-1:0]         out_col,
  input wire logic signed [ACC_W-1:0]  product,
  input wire logic                     row_done
);

  // A stalled result holds its value until the transfer.
  `ASSERT_NEXT(a_result_hold, clk, rst, result_valid && result_stall, result_valid && $stable(product) && $stable(out_col) && $stable(row_done))

  // A stalled item stays offered until the transfer.
  `ASSERT_NEXT(a_item_hold, clk, rst, item_valid && item_stall, item_valid)

  // No item is taken while a row is being emitted.
  `ASSERT_SAME(a_no_take_during_emit, clk, rst, result_valid, item_stall)

  // The final result of a row ends the emission.
  `ASSERT_NEXT(a_row_end, clk, rst, result_valid && !result_stall && row_done, !result_valid && !item_stall)

  // A row that follows a finished row starts at column zero.
  `ASSERT_SAME(a_row_start, clk, rst, $rose(result_valid) && $past(row_done), out_col == '0)

endmodule

bind matrix_row_multiply_accumulate mrma_checker u_mrma_checker (.*);

`default_nettype wire
